// ===== hw/rtl/mlam_pkg.sv =====
// shared constants, codes and types of the motor link ack monitor
package mlam_pkg;

    localparam int CHANNELS_DEF = 16;

    localparam int CH_W        = 4;
    localparam int BYTE_W      = 8;
    localparam int TICK_W      = 4;
    localparam int STALE_W     = 20;
    localparam int OUT_STALE_W = 21;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [STALE_W-1:0] STALE_MAX    = 20'd1000000;
    localparam logic [BYTE_W-1:0]  WINDOW_RESET = 8'd250;
    localparam logic               ACK_RESET    = 1'b1;

    // item kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_ENABLE  = 1'b0,
        CFG_LINK_WINDOW = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/mlam_if.sv =====
// item channels: poll/tick input and result output
interface mlam_in_if;
    import mlam_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CH_W-1:0]   channel;
    logic              received;
    logic [BYTE_W-1:0] motor_status;
    logic [BYTE_W-1:0] echo_command;

    modport source (output valid, cmd, channel, received, motor_status, echo_command,
                    input ready);
    modport sink (input valid, cmd, channel, received, motor_status, echo_command,
                  output ready);
endinterface

interface mlam_out_if;
    import mlam_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [BYTE_W-1:0]             command_byte;
    logic [CH_W-1:0]               poll_channel;
    logic                          connected;
    logic [BYTE_W-1:0]             last_status;
    logic [TICK_W-1:0]             ack_lag;
    logic signed [OUT_STALE_W-1:0] echo_stale;

    modport source (output valid, command_byte, poll_channel, connected, last_status,
                    ack_lag, echo_stale, input ready);
    modport sink (input valid, command_byte, poll_channel, connected, last_status,
                  ack_lag, echo_stale, output ready);
endinterface

// ===== hw/rtl/motor_link_ack_monitor.sv =====
// top level: per-channel link health and command echo monitor
// a result is loaded into the result register once its item has passed the capture register and the exec state,
// which waits for a free result slot; items are taken one at a time, each after the capture/update sequence of the last
// the input side takes the next item while the previous result waits in the output register
// reset: synchronous active low; clears tick, all per-channel state and the result valid,
// and loads ack_enable = 1 and link_window = 250
module motor_link_ack_monitor #(
    parameter int CHANNELS = mlam_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mlam_in_if.sink                         i_item,
    mlam_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [mlam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mlam_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mlam_pkg::*;

    // command and status between controller and datapath
    t_ctrl_cmd  ctl;
    t_dp_status sts;

    // sequencer: idle (ready) -> exec (update state, load result) -> idle
    mlam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // per-channel stores, tick counter, config registers and result register
    mlam_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_item.cmd),
        .i_channel      (i_item.channel),
        .i_received     (i_item.received),
        .i_motor_status (i_item.motor_status),
        .i_echo_command (i_item.echo_command),
        .o_valid        (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_command_byte (o_res.command_byte),
        .o_poll_channel (o_res.poll_channel),
        .o_connected    (o_res.connected),
        .o_last_status  (o_res.last_status),
        .o_ack_lag      (o_res.ack_lag),
        .o_echo_stale   (o_res.echo_stale)
    );

endmodule

// ===== hw/rtl/mlam_ctrl.sv =====
// controller: takes one item, waits for a free result slot, then runs its update
module mlam_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mlam_pkg::t_dp_status i_sts,
    output mlam_pkg::t_ctrl_cmd  o_ctl
);
    import mlam_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_ctl.capture = 1'b0;
        o_ctl.exec    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_ctl.capture = i_valid;
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // result register must be empty or draining this cycle
                o_ctl.exec = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mlam_datapath.sv =====
// datapath: config, tick, per-channel link/echo state and result register
module mlam_datapath #(
    parameter int CHANNELS = mlam_pkg::CHANNELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mlam_pkg::t_ctrl_cmd                  i_ctl,
    output mlam_pkg::t_dp_status                 o_sts,
    input  logic                                 i_cfg_we,
    input  logic [mlam_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mlam_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_cmd,
    input  logic [mlam_pkg::CH_W-1:0]            i_channel,
    input  logic                                 i_received,
    input  logic [mlam_pkg::BYTE_W-1:0]          i_motor_status,
    input  logic [mlam_pkg::BYTE_W-1:0]          i_echo_command,
    output logic                                 o_valid,
    input  logic                                 i_out_ready,
    output logic [mlam_pkg::BYTE_W-1:0]          o_command_byte,
    output logic [mlam_pkg::CH_W-1:0]            o_poll_channel,
    output logic                                 o_connected,
    output logic [mlam_pkg::BYTE_W-1:0]          o_last_status,
    output logic [mlam_pkg::TICK_W-1:0]          o_ack_lag,
    output logic signed [mlam_pkg::OUT_STALE_W-1:0] o_echo_stale
);
    import mlam_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = IDX_W + CH_W;

    // captured item
    logic              r_cmd;
    logic [CH_W-1:0]   r_channel;
    logic              r_rx;
    logic [BYTE_W-1:0] r_st;
    logic [BYTE_W-1:0] r_echo;

    logic              r_ack_en;
    logic [BYTE_W-1:0] r_window;
    logic [TICK_W-1:0] r_tick;

    logic [BYTE_W-1:0]  r_link   [CHANNELS];
    logic [BYTE_W-1:0]  r_status [CHANNELS];
    logic               r_seen   [CHANNELS];
    logic [TICK_W-1:0]  r_nib    [CHANNELS];
    logic [STALE_W-1:0] r_stale  [CHANNELS];
    logic [TICK_W-1:0]  r_lag    [CHANNELS];

    logic                          r_valid;
    logic [BYTE_W-1:0]             r_cmd_byte;
    logic [CH_W-1:0]               r_poll_ch;
    logic                          r_conn;
    logic [BYTE_W-1:0]             r_last_st;
    logic [TICK_W-1:0]             r_ack_lag;
    logic signed [OUT_STALE_W-1:0] r_echo_stale;

    logic [EXT_W-1:0]   ch_ext;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [TICK_W-1:0]  nib;
    logic [TICK_W-1:0]  n_tick;
    logic [BYTE_W-1:0]  n_link;
    logic [BYTE_W-1:0]  n_status;
    logic               n_seen;
    logic [TICK_W-1:0]  n_nib;
    logic [STALE_W-1:0] n_stale;
    logic [TICK_W-1:0]  n_lag;
    logic               same_nib;

    logic [BYTE_W-1:0]             n_cmd_byte;
    logic [CH_W-1:0]               n_poll_ch;
    logic                          n_conn;
    logic [BYTE_W-1:0]             n_last_st;
    logic [TICK_W-1:0]             n_ack_lag;
    logic signed [OUT_STALE_W-1:0] n_echo_stale;

    assign o_sts.out_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd     <= i_cmd;
            r_channel <= i_channel;
            r_rx      <= i_received;
            r_st      <= i_motor_status;
            r_echo    <= i_echo_command;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_en <= ACK_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACK_ENABLE:  r_ack_en <= i_cfg_data[0];
                CFG_LINK_WINDOW: r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ch_ext   = EXT_W'(r_channel);
        idx      = ch_ext[IDX_W-1:0];
        in_range = ch_ext < EXT_W'(CHANNELS);
        nib      = r_echo[BYTE_W-1:BYTE_W-TICK_W];
        n_tick   = r_tick + TICK_W'(1);
        same_nib = r_seen[idx] && (r_nib[idx] == nib);

        if (r_rx) begin
            n_link   = r_window;
            n_status = r_st;
            n_seen   = 1'b1;
            n_nib    = nib;
            n_lag    = r_tick - nib;
            if (!same_nib) begin
                n_stale = '0;
            end else if (r_stale[idx] < STALE_MAX) begin
                n_stale = r_stale[idx] + STALE_W'(1);
            end else begin
                n_stale = r_stale[idx];
            end
        end else begin
            n_link   = (r_link[idx] != '0) ? r_link[idx] - BYTE_W'(1) : '0;
            n_status = r_status[idx];
            n_seen   = r_seen[idx];
            n_nib    = r_nib[idx];
            n_lag    = r_lag[idx];
            n_stale  = r_stale[idx];
        end

        n_cmd_byte   = '0;
        n_poll_ch    = '0;
        n_conn       = 1'b0;
        n_last_st    = '0;
        n_ack_lag    = '0;
        n_echo_stale = '0;
        if (r_cmd == CMD_TICK) begin
            n_cmd_byte = r_ack_en ? {n_tick, {(BYTE_W-TICK_W){1'b0}}} : '0;
        end else if (!in_range) begin
            n_poll_ch    = r_channel;
            n_echo_stale = '1;
        end else begin
            n_poll_ch    = r_channel;
            n_conn       = n_link != '0;
            n_last_st    = n_status;
            n_ack_lag    = n_lag;
            n_echo_stale = n_seen ? $signed({1'b0, n_stale}) : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_link[i]   <= '0;
                r_status[i] <= '0;
                r_seen[i]   <= 1'b0;
                r_nib[i]    <= '0;
                r_stale[i]  <= '0;
                r_lag[i]    <= '0;
            end
        end else if (i_ctl.exec) begin
            if (r_cmd == CMD_TICK) begin
                r_tick <= n_tick;
            end else if (in_range) begin
                r_link[idx]   <= n_link;
                r_status[idx] <= n_status;
                r_seen[idx]   <= n_seen;
                r_nib[idx]    <= n_nib;
                r_stale[idx]  <= n_stale;
                r_lag[idx]    <= n_lag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.exec) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_cmd_byte   <= n_cmd_byte;
            r_poll_ch    <= n_poll_ch;
            r_conn       <= n_conn;
            r_last_st    <= n_last_st;
            r_ack_lag    <= n_ack_lag;
            r_echo_stale <= n_echo_stale;
        end
    end

    assign o_valid        = r_valid;
    assign o_command_byte = r_cmd_byte;
    assign o_poll_channel = r_poll_ch;
    assign o_connected    = r_conn;
    assign o_last_status  = r_last_st;
    assign o_ack_lag      = r_ack_lag;
    assign o_echo_stale   = r_echo_stale;

endmodule

// ===== hw/rtl/mlam_checker.sv =====
// port-level checks of the motor link ack monitor, bound to the top level
module mlam_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic [mlam_pkg::BYTE_W-1:0]           i_command_byte,
    input logic                                  i_connected,
    input logic [mlam_pkg::BYTE_W-1:0]           i_last_status,
    input logic [mlam_pkg::TICK_W-1:0]           i_ack_lag,
    input logic signed [mlam_pkg::OUT_STALE_W-1:0] i_echo_stale
);
    import mlam_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_command_byte)
            && $stable(i_echo_stale))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accept");

    // command byte carries the tick in the upper nibble only
    a_cmd_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_command_byte[TICK_W-1:0] == '0)
        else $error("command byte low nibble not zero");

    // a channel that never echoed never received, so it shows nothing
    a_never_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_echo_stale == -21'sd1 |->
            !i_connected && i_last_status == '0 && i_ack_lag == '0)
        else $error("channel without echo shows link data");

endmodule

bind motor_link_ack_monitor mlam_checker u_mlam_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_command_byte (o_res.command_byte),
    .i_connected    (o_res.connected),
    .i_last_status  (o_res.last_status),
    .i_ack_lag      (o_res.ack_lag),
    .i_echo_stale   (o_res.echo_stale)
);
